### sv/kcb_pkg.sv
// ----------------------------------------------------------------------------
// kcb_pkg: shared types and constants of the convolution block
// Field widths, reset values, register indexes and the records passed
// between the front end, the item queue and the compute back end.
// ----------------------------------------------------------------------------
`default_nettype none

package kcb_pkg;

   // defaults for the top level parameters
   localparam int MAX_KERNEL_SIZE_DEF = 9;
   localparam int MAX_WIDTH_DEF       = 1024;
   localparam int COEF_BITS_DEF       = 8;

   localparam int MAX_HEIGHT  = 4096;
   localparam int QUEUE_DEPTH = 2;

   // field and internal widths (sized for the largest parameter values)
   localparam int COL_W      = 12;
   localparam int ROW_W      = 12;
   localparam int SLOT_W     = 4;
   localparam int TAP_W      = 4;
   localparam int RAD_W      = 3;
   localparam int COEF_MAX_W = 16;
   localparam int CIDX_W     = 7;
   localparam int PIX_W      = 8;
   localparam int OUTX_W     = 10;
   localparam int OUTY_W     = 12;
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int BIAS_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DAT_W  = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_RADIUS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_BIAS   = 2'd3;

   // register reset values
   localparam logic [FW_W-1:0]   FRAME_WIDTH_RST   = 11'd640;
   localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST  = 13'd480;
   localparam logic [RAD_W-1:0]  KERNEL_RADIUS_RST = 3'd4;
   localparam logic [BIAS_W-1:0] OUTPUT_BIAS_RST   = 16'd127;

   // item commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_COEF  = 1'b1;

   // effective frame settings, limits already applied
   typedef struct packed {
      logic [COL_W-1:0]         w_last;
      logic [ROW_W-1:0]         h_last;
      logic [RAD_W-1:0]         radius;
      logic signed [BIAS_W-1:0] bias;
   } cfg_type;

   // one classified item waiting for the back end
   typedef struct packed {
      logic                         cmd;
      logic [PIX_W-1:0]             pixel;
      logic [CIDX_W-1:0]            coef_index;
      logic                         coef_ok;
      logic signed [COEF_MAX_W-1:0] coef_value;
      logic [COL_W-1:0]             x;
      logic [ROW_W-1:0]             y;
      logic [SLOT_W-1:0]            slot_y;
      logic                         emit;
      logic [COL_W-1:0]             cx0;
      logic [COL_W-1:0]             cx1;
      logic [ROW_W-1:0]             ry0;
      logic [ROW_W-1:0]             ry1;
   } qentry_type;

endpackage

`default_nettype wire

### sv/kernel_convolution_bias_clamp.sv
// ----------------------------------------------------------------------------
// kernel_convolution_bias_clamp: streaming 2-D convolution, bias and clamp
// Convolves a raster-order 8-bit frame with a square signed kernel (flipped,
// zero outside the frame), adds a bias and clamps each result to 0..255.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  cmd, pixel_value, coef_index,
//                                            coef_value
//   rsp      out        rsp_valid/rsp_ready  out_x, out_y, out_value,
//                                            clamped, last
//   csr      in         csr_we               csr_index, csr_wdata
//
// An item that causes no result leaves the queue without starting the engine.
// An item with results walks each result through its (2r+1)^2 kernel taps,
// one tap a cycle through the single multiply-accumulate pipeline, whose line
// buffer has one read port, and then waits for the pipeline to drain.
// Synchronous reset clears counters, queue, controls and weight valid flags
// (weights then read as zero). The queue takes items until full while the
// engine or the output stalls; a stalled output holds the engine while it stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_convolution_bias_clamp #(
   parameter int MAX_KERNEL_SIZE = kcb_pkg::MAX_KERNEL_SIZE_DEF,
   parameter int MAX_WIDTH       = kcb_pkg::MAX_WIDTH_DEF,
   parameter int COEF_BITS       = kcb_pkg::COEF_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_cmd,
   input  wire [kcb_pkg::PIX_W-1:0]          req_pixel_value,
   input  wire [kcb_pkg::CIDX_W-1:0]         req_coef_index,
   input  wire [COEF_BITS-1:0]               req_coef_value,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [kcb_pkg::OUTX_W-1:0]        rsp_out_x,
   output logic [kcb_pkg::OUTY_W-1:0]        rsp_out_y,
   output logic [kcb_pkg::PIX_W-1:0]         rsp_out_value,
   output logic                              rsp_clamped,
   output logic                              rsp_last,
   input  wire                               csr_we,
   input  wire [kcb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [kcb_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   logic [kcb_pkg::FW_W-1:0]   frame_width_ff;
   logic [kcb_pkg::FH_W-1:0]   frame_height_ff;
   logic [kcb_pkg::RAD_W-1:0]  kernel_radius_ff;
   logic [kcb_pkg::BIAS_W-1:0] output_bias_ff;

   kcb_pkg::cfg_type    cfg;
   kcb_pkg::qentry_type push_entry, head;
   logic                q_push, q_pop, q_full, q_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= kcb_pkg::FRAME_WIDTH_RST;
         frame_height_ff  <= kcb_pkg::FRAME_HEIGHT_RST;
         kernel_radius_ff <= kcb_pkg::KERNEL_RADIUS_RST;
         output_bias_ff   <= kcb_pkg::OUTPUT_BIAS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            kcb_pkg::CSR_FRAME_WIDTH:   frame_width_ff   <= csr_wdata[kcb_pkg::FW_W-1:0];
            kcb_pkg::CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_wdata[kcb_pkg::FH_W-1:0];
            kcb_pkg::CSR_KERNEL_RADIUS: kernel_radius_ff <= csr_wdata[kcb_pkg::RAD_W-1:0];
            kcb_pkg::CSR_OUTPUT_BIAS:   output_bias_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // limits applied to the frame settings
   always_comb begin
      if (frame_width_ff == '0) begin
         cfg.w_last = '0;
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         cfg.w_last = kcb_pkg::COL_W'(MAX_WIDTH - 1);
      end else begin
         cfg.w_last = kcb_pkg::COL_W'(frame_width_ff - 1'b1);
      end
      if (frame_height_ff == '0) begin
         cfg.h_last = '0;
      end else if (int'(frame_height_ff) > kcb_pkg::MAX_HEIGHT) begin
         cfg.h_last = kcb_pkg::ROW_W'(kcb_pkg::MAX_HEIGHT - 1);
      end else begin
         cfg.h_last = kcb_pkg::ROW_W'(frame_height_ff - 1'b1);
      end
      if (int'(kernel_radius_ff) > (MAX_KERNEL_SIZE - 1) / 2) begin
         cfg.radius = kcb_pkg::RAD_W'((MAX_KERNEL_SIZE - 1) / 2);
      end else begin
         cfg.radius = kernel_radius_ff;
      end
      cfg.bias = $signed(output_bias_ff);
   end

   kcb_front #(
      .MAX_KERNEL_SIZE (MAX_KERNEL_SIZE),
      .COEF_BITS       (COEF_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_pixel_value (req_pixel_value),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .cfg             (cfg),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (push_entry)
   );

   kcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   kcb_back #(
      .MAX_KERNEL_SIZE (MAX_KERNEL_SIZE),
      .MAX_WIDTH       (MAX_WIDTH),
      .COEF_BITS       (COEF_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .head          (head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_value (rsp_out_value),
      .rsp_clamped   (rsp_clamped),
      .rsp_last      (rsp_last)
   );

`ifndef ASSERT_OFF
   // the queue is never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("item pushed into a full queue");

   // the queue is never read while empty
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("item popped from an empty queue");

   // a saturated result sits at one of the clamp limits
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clamped) |-> (rsp_out_value == 8'd0 || rsp_out_value == 8'd255))
      else $error("clamped flag without a limit value");

   // result coordinates lie inside the frame
   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (kcb_pkg::COL_W'(rsp_out_x) <= cfg.w_last &&
                     kcb_pkg::ROW_W'(rsp_out_y) <= cfg.h_last))
      else $error("result outside the frame");
`endif

endmodule

`default_nettype wire

### sv/kcb_front.sv
// ----------------------------------------------------------------------------
// kcb_front: item intake and classification
// Tracks the raster position, works out the line buffer slot and the span
// of results each pixel releases, and pushes the item into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module kcb_front #(
   parameter int MAX_KERNEL_SIZE = kcb_pkg::MAX_KERNEL_SIZE_DEF,
   parameter int COEF_BITS       = kcb_pkg::COEF_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire                             req_cmd,
   input  wire [kcb_pkg::PIX_W-1:0]        req_pixel_value,
   input  wire [kcb_pkg::CIDX_W-1:0]       req_coef_index,
   input  wire [COEF_BITS-1:0]             req_coef_value,
   input  kcb_pkg::cfg_type                cfg,
   input  wire                             q_full,
   output logic                            q_push,
   output kcb_pkg::qentry_type             q_entry
);

   localparam int K     = MAX_KERNEL_SIZE;
   localparam int RECIP = 65536 / MAX_KERNEL_SIZE;

   logic [kcb_pkg::COL_W-1:0] col_ff, col_in;
   logic [kcb_pkg::ROW_W-1:0] row_ff, row_in;
   logic [kcb_pkg::COL_W-1:0] x;
   logic [kcb_pkg::ROW_W-1:0] y;
   logic [kcb_pkg::COL_W-1:0] r_col;
   logic [kcb_pkg::ROW_W-1:0] r_row;
   logic                      x_end, y_end;

   // row modulo kernel size: reciprocal multiply and one correction
   function automatic logic [kcb_pkg::SLOT_W-1:0] mod_k(input logic [kcb_pkg::ROW_W-1:0] v);
      int q;
      int rem;
      q   = (int'(v) * RECIP) >>> 16;
      rem = int'(v) - q * K;
      if (rem >= K) begin
         rem = rem - K;
      end
      return kcb_pkg::SLOT_W'(rem);
   endfunction

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // position, saturated into the current frame
   always_comb begin
      x     = (col_ff > cfg.w_last) ? cfg.w_last : col_ff;
      y     = (row_ff > cfg.h_last) ? cfg.h_last : row_ff;
      r_col = kcb_pkg::COL_W'(cfg.radius);
      r_row = kcb_pkg::ROW_W'(cfg.radius);
      x_end = (x == cfg.w_last);
      y_end = (y == cfg.h_last);
   end

   // classify the item
   always_comb begin
      q_entry            = '0;
      q_entry.cmd        = req_cmd;
      q_entry.pixel      = req_pixel_value;
      q_entry.coef_index = req_coef_index;
      q_entry.coef_ok    = (int'(req_coef_index) < K * K);
      q_entry.coef_value = kcb_pkg::COEF_MAX_W'($signed(req_coef_value));
      q_entry.x          = x;
      q_entry.y          = y;
      q_entry.slot_y     = mod_k(y);
      q_entry.emit       = (x_end || x >= r_col) && (y_end || y >= r_row);
      if (x_end) begin
         q_entry.cx0 = (x >= r_col) ? x - r_col : '0;
         q_entry.cx1 = cfg.w_last;
      end else begin
         q_entry.cx0 = x - r_col;
         q_entry.cx1 = x - r_col;
      end
      if (y_end) begin
         q_entry.ry0 = (y >= r_row) ? y - r_row : '0;
         q_entry.ry1 = cfg.h_last;
      end else begin
         q_entry.ry0 = y - r_row;
         q_entry.ry1 = y - r_row;
      end
   end

   // raster counters advance on pixel items only
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (q_push && req_cmd == kcb_pkg::CMD_PIXEL) begin
         if (x_end) begin
            col_in = '0;
            row_in = y_end ? '0 : y + 1'b1;
         end else begin
            col_in = x + 1'b1;
            row_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

### sv/kcb_queue.sv
// ----------------------------------------------------------------------------
// kcb_queue: short item queue between front and back end
// A small register queue so intake and computation can stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module kcb_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  kcb_pkg::qentry_type  push_entry,
   input  wire                  pop,
   output kcb_pkg::qentry_type  head,
   output logic                 full,
   output logic                 empty
);

   localparam int DEPTH = kcb_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kcb_pkg::qentry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### sv/kcb_back.sv
// ----------------------------------------------------------------------------
// kcb_back: line buffer, coefficient store and multiply-accumulate engine
// Writes pixels and weights in item order, then walks every result of an
// item through one tap per cycle into a pipelined MAC and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kcb_back #(
   parameter int MAX_KERNEL_SIZE = kcb_pkg::MAX_KERNEL_SIZE_DEF,
   parameter int MAX_WIDTH       = kcb_pkg::MAX_WIDTH_DEF,
   parameter int COEF_BITS       = kcb_pkg::COEF_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  kcb_pkg::cfg_type             cfg,
   input  kcb_pkg::qentry_type          head,
   input  wire                          q_empty,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [kcb_pkg::OUTX_W-1:0]   rsp_out_x,
   output logic [kcb_pkg::OUTY_W-1:0]   rsp_out_y,
   output logic [kcb_pkg::PIX_W-1:0]    rsp_out_value,
   output logic                         rsp_clamped,
   output logic                         rsp_last
);

   localparam int K      = MAX_KERNEL_SIZE;
   localparam int KK     = K * K;
   localparam int CA_W   = (KK > 1) ? $clog2(KK) : 1;
   localparam int LA_W   = $clog2(K * MAX_WIDTH);
   localparam int PROD_W = COEF_BITS + 9;
   localparam int ACC_W  = PROD_W + $clog2(KK + 1);
   localparam int SUM_W  = ((ACC_W > kcb_pkg::BIAS_W) ? ACC_W : kcb_pkg::BIAS_W) + 1;
   localparam int PX_W   = kcb_pkg::COL_W + 2;
   localparam int PY_W   = kcb_pkg::ROW_W + 2;

   typedef enum logic [1:0] {S_IDLE, S_TAP, S_WAIT} state_type;

   state_type               state_ff;
   kcb_pkg::qentry_type     cur_ff;
   logic [kcb_pkg::COL_W-1:0] ox_ff;
   logic [kcb_pkg::ROW_W-1:0] oy_ff;
   logic [kcb_pkg::TAP_W-1:0] ti_ff, tj_ff;

   // memories
   logic [kcb_pkg::PIX_W-1:0] line_mem [K * MAX_WIDTH];
   logic [COEF_BITS-1:0]      coef_mem [KK];
   logic [KK-1:0]             coef_vld_ff;

   // MAC pipeline
   logic                      v2_ff, last2_ff, inb2_ff;
   logic [kcb_pkg::PIX_W-1:0] line_q_ff;
   logic [COEF_BITS-1:0]      coef_q_ff;
   logic                      coef_v_ff;
   logic                      v3_ff, last3_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      acc_done_ff;
   logic                      acc_clr;

   // tap address generation
   logic [kcb_pkg::TAP_W-1:0] r2;
   logic                      tap_last;
   logic signed [PX_W-1:0]    px;
   logic signed [PY_W-1:0]    py;
   logic signed [PY_W-1:0]    row_dist;
   logic [kcb_pkg::SLOT_W-1:0] dn, slot;
   logic                      inb;
   logic [LA_W-1:0]           line_ra, line_wa;
   logic [CA_W-1:0]           coef_ra, coef_wa;
   logic                      line_we, coef_we;

   // result formation
   logic signed [SUM_W-1:0]   sum;
   logic [kcb_pkg::PIX_W-1:0] value;
   logic                      sat;
   logic                      out_free;
   logic                      res_last;
   logic                      res_fire;

   assign q_pop    = (state_ff == S_IDLE) && !q_empty;
   assign line_we  = q_pop && head.cmd == kcb_pkg::CMD_PIXEL;
   assign coef_we  = q_pop && head.cmd == kcb_pkg::CMD_COEF && head.coef_ok;
   assign line_wa  = LA_W'(int'(head.slot_y) * MAX_WIDTH + int'(head.x));
   assign coef_wa  = CA_W'(head.coef_index);
   assign out_free = !rsp_valid || rsp_ready;
   assign res_last = (ox_ff == cur_ff.cx1) && (oy_ff == cur_ff.ry1);
   assign res_fire = (state_ff == S_WAIT) && acc_done_ff && out_free;

   // current tap: source pixel, bounds and line slot
   always_comb begin
      r2       = kcb_pkg::TAP_W'({cfg.radius, 1'b0});
      tap_last = (ti_ff == r2) && (tj_ff == r2);
      px       = signed'(PX_W'(ox_ff)) + signed'(PX_W'(cfg.radius)) - signed'(PX_W'(tj_ff));
      py       = signed'(PY_W'(oy_ff)) + signed'(PY_W'(cfg.radius)) - signed'(PY_W'(ti_ff));
      inb      = (px >= 0) && (px <= signed'(PX_W'(cfg.w_last))) &&
                 (py >= 0) && (py <= signed'(PY_W'(cfg.h_last)));
      row_dist = signed'(PY_W'(cur_ff.y)) - py;
      dn       = row_dist[kcb_pkg::SLOT_W-1:0];
      slot     = (cur_ff.slot_y >= dn) ? cur_ff.slot_y - dn
                                       : cur_ff.slot_y + kcb_pkg::SLOT_W'(K) - dn;
      line_ra  = LA_W'(int'(slot) * MAX_WIDTH + int'(px[kcb_pkg::COL_W-1:0]));
      coef_ra  = CA_W'(int'(ti_ff) * K + int'(tj_ff));
   end

   // line buffer
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_wa] <= head.pixel;
      end
      line_q_ff <= line_mem[line_ra];
   end

   // coefficient store, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= COEF_BITS'(head.coef_value);
      end
      coef_q_ff <= coef_mem[coef_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         coef_v_ff   <= 1'b0;
      end else begin
         if (coef_we) begin
            coef_vld_ff[coef_wa] <= 1'b1;
         end
         coef_v_ff <= coef_vld_ff[coef_ra];
      end
   end

   // product of weight and pixel, zero outside the frame
   always_comb begin
      prod_in = '0;
      if (inb2_ff && coef_v_ff) begin
         prod_in = PROD_W'($signed(coef_q_ff) * $signed({1'b0, line_q_ff}));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      inb2_ff <= inb;
      if (acc_clr) begin
         acc_ff <= '0;
      end else if (v3_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff    <= 1'b0;
         last2_ff <= 1'b0;
         v3_ff    <= 1'b0;
         last3_ff <= 1'b0;
      end else begin
         v2_ff    <= (state_ff == S_TAP);
         last2_ff <= (state_ff == S_TAP) && tap_last;
         v3_ff    <= v2_ff;
         last3_ff <= last2_ff;
      end
   end

   // bias and clamp
   always_comb begin
      sum = SUM_W'(acc_ff) + SUM_W'(cfg.bias);
      sat = 1'b0;
      if (sum < 0) begin
         value = '0;
         sat   = 1'b1;
      end else if (sum > SUM_W'(255)) begin
         value = 8'd255;
         sat   = 1'b1;
      end else begin
         value = sum[kcb_pkg::PIX_W-1:0];
      end
   end

   assign acc_clr = (q_pop && head.cmd == kcb_pkg::CMD_PIXEL && head.emit) ||
                    (res_fire && !res_last);

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         acc_done_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         if (res_fire) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         if (res_fire) begin
            acc_done_ff <= 1'b0;
         end else if (v3_ff && last3_ff) begin
            acc_done_ff <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cur_ff <= head;
                  ox_ff  <= head.cx0;
                  oy_ff  <= head.ry0;
                  ti_ff  <= '0;
                  tj_ff  <= '0;
                  if (head.cmd == kcb_pkg::CMD_PIXEL && head.emit) begin
                     state_ff <= S_TAP;
                  end
               end
            end
            S_TAP: begin
               if (tap_last) begin
                  state_ff <= S_WAIT;
               end else if (tj_ff == r2) begin
                  tj_ff <= '0;
                  ti_ff <= ti_ff + 1'b1;
               end else begin
                  tj_ff <= tj_ff + 1'b1;
               end
            end
            S_WAIT: begin
               if (res_fire) begin
                  rsp_out_x     <= kcb_pkg::OUTX_W'(ox_ff);
                  rsp_out_y     <= kcb_pkg::OUTY_W'(oy_ff);
                  rsp_out_value <= value;
                  rsp_clamped   <= sat;
                  rsp_last      <= res_last;
                  ti_ff         <= '0;
                  tj_ff         <= '0;
                  if (res_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_TAP;
                     if (ox_ff == cur_ff.cx1) begin
                        ox_ff <= cur_ff.cx0;
                        oy_ff <= oy_ff + 1'b1;
                     end else begin
                        ox_ff <= ox_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### verif/kernel_convolution_bias_clamp_tb.sv
// ----------------------------------------------------------------------------
// kernel_convolution_bias_clamp_tb: self-checking bench of the convolution block
// Drives coefficient and pixel items and register settings. The bench keeps its
// own model of the line store, weights and raster counters, predicts every
// output pixel and compares each one, field by field, in arrival order. Both
// channels stall at random. The frames include the edge cases of the registers
// and also shrink the frame partway through a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module kernel_convolution_bias_clamp_tb;

   localparam int KSIZE = kcb_pkg::MAX_KERNEL_SIZE_DEF;
   localparam int KSQ   = KSIZE * KSIZE;
   localparam int WMAX  = kcb_pkg::MAX_WIDTH_DEF;

   typedef struct {
      bit [kcb_pkg::OUTX_W-1:0] x;
      bit [kcb_pkg::OUTY_W-1:0] y;
      bit [kcb_pkg::PIX_W-1:0]  value;
      bit                       clamped;
      bit                       last;
   } out_pixel_type;

   // model of the convolution and store of pixels still due
   class conv_book_type;
      bit [kcb_pkg::PIX_W-1:0]  lines [KSIZE*WMAX];
      int                       weights [KSQ];
      int                       col, row;
      bit [kcb_pkg::FW_W-1:0]   fw;
      bit [kcb_pkg::FH_W-1:0]   fh;
      bit [kcb_pkg::RAD_W-1:0]  rad;
      bit [kcb_pkg::BIAS_W-1:0] bias;
      out_pixel_type            due_pixels [$];
      int                       fails;

      function new();
         foreach (lines[i]) lines[i] = '0;
         foreach (weights[i]) weights[i] = 0;
         col = 0;
         row = 0;
         fw = kcb_pkg::FRAME_WIDTH_RST;
         fh = kcb_pkg::FRAME_HEIGHT_RST;
         rad = kcb_pkg::KERNEL_RADIUS_RST;
         bias = kcb_pkg::OUTPUT_BIAS_RST;
         fails = 0;
      endfunction

      function void write_reg(bit [kcb_pkg::CSR_IDX_W-1:0] idx,
                              bit [kcb_pkg::CSR_DAT_W-1:0] d);
         case (idx)
            kcb_pkg::CSR_FRAME_WIDTH: fw = d[kcb_pkg::FW_W-1:0];
            kcb_pkg::CSR_FRAME_HEIGHT: fh = d[kcb_pkg::FH_W-1:0];
            kcb_pkg::CSR_KERNEL_RADIUS: rad = d[kcb_pkg::RAD_W-1:0];
            kcb_pkg::CSR_OUTPUT_BIAS: bias = d[kcb_pkg::BIAS_W-1:0];
            default: ;
         endcase
      endfunction

      function int pix(int px, int py, int w, int h);
         if (px < 0 || py < 0 || px >= w || py >= h) return 0;
         return lines[(py % KSIZE) * WMAX + px];
      endfunction

      // weighted sum of one output pixel, flipped kernel, then bias and clamp
      function void add_pixel(int ox, int oy, int r, int w, int h, bit lst);
         longint        acc;
         out_pixel_type o;
         acc = 0;
         for (int ky = -r; ky <= r; ky++)
            for (int kx = -r; kx <= r; kx++)
               acc += longint'(weights[(ky + r) * KSIZE + kx + r]) *
                      pix(ox - kx, oy - ky, w, h);
         acc += $signed(bias);
         o.clamped = 1'b0;
         if (acc < 0) begin
            acc = 0;
            o.clamped = 1'b1;
         end else if (acc > 255) begin
            acc = 255;
            o.clamped = 1'b1;
         end
         o.x = ox[kcb_pkg::OUTX_W-1:0];
         o.y = oy[kcb_pkg::OUTY_W-1:0];
         o.value = acc[7:0];
         o.last = lst;
         due_pixels.push_back(o);
      endfunction

      function void take_item(bit cmd, bit [kcb_pkg::PIX_W-1:0] pv,
                              bit [kcb_pkg::CIDX_W-1:0] ci, bit [7:0] cv);
         int w, h, r, x, y, cx0, cx1, ry0, ry1;
         if (cmd == kcb_pkg::CMD_COEF) begin
            if (ci < KSQ) weights[ci] = $signed(cv);
            return;
         end
         w = (fw < 1) ? 1 : (fw > WMAX) ? WMAX : fw;
         h = (fh < 1) ? 1 : (fh > kcb_pkg::MAX_HEIGHT) ? kcb_pkg::MAX_HEIGHT : fh;
         r = (rad > (KSIZE - 1) / 2) ? (KSIZE - 1) / 2 : rad;
         x = (col > w - 1) ? w - 1 : col;
         y = (row > h - 1) ? h - 1 : row;
         lines[(y % KSIZE) * WMAX + x] = pv;
         cx0 = x - r;
         cx1 = x - r;
         ry0 = y - r;
         ry1 = y - r;
         // row and frame ends flush everything still due
         if (x == w - 1) begin
            cx0 = (x - r < 0) ? 0 : x - r;
            cx1 = w - 1;
         end
         if (y == h - 1) begin
            ry0 = (y - r < 0) ? 0 : y - r;
            ry1 = h - 1;
         end
         if (cx0 >= 0 && ry0 >= 0)
            for (int oy = ry0; oy <= ry1; oy++)
               for (int ox = cx0; ox <= cx1; ox++)
                  add_pixel(ox, oy, r, w, h, oy == ry1 && ox == cx1);
         if (x == w - 1) begin
            col = 0;
            row = (y == h - 1) ? 0 : y + 1;
         end else begin
            col = x + 1;
            row = y;
         end
      endfunction

      function void check_pixel(out_pixel_type got);
         out_pixel_type exp;
         if (due_pixels.size() == 0) begin
            $error("output pixel (%0d,%0d) with none due", got.x, got.y);
            fails++;
            return;
         end
         exp = due_pixels.pop_front();
         if (got.x != exp.x) begin
            $error("out_x: expected %0d, got %0d", exp.x, got.x);
            fails++;
         end
         if (got.y != exp.y) begin
            $error("out_y: expected %0d, got %0d", exp.y, got.y);
            fails++;
         end
         if (got.value != exp.value) begin
            $error("out_value: expected %0d, got %0d", exp.value, got.value);
            fails++;
         end
         if (got.clamped != exp.clamped) begin
            $error("clamped: expected %0d, got %0d", exp.clamped, got.clamped);
            fails++;
         end
         if (got.last != exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            fails++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_cmd = kcb_pkg::CMD_PIXEL;
   logic [kcb_pkg::PIX_W-1:0]     req_pixel_value = '0;
   logic [kcb_pkg::CIDX_W-1:0]    req_coef_index = '0;
   logic [7:0]                    req_coef_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [kcb_pkg::OUTX_W-1:0]    rsp_out_x;
   logic [kcb_pkg::OUTY_W-1:0]    rsp_out_y;
   logic [kcb_pkg::PIX_W-1:0]     rsp_out_value;
   logic                          rsp_clamped;
   logic                          rsp_last;
   logic                          csr_we = 1'b0;
   logic [kcb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [kcb_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   conv_book_type book = new();
   bit            calm = 1'b0;
   int            fed = 0;

   kernel_convolution_bias_clamp uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_pixel_value(req_pixel_value), .req_coef_index(req_coef_index),
      .req_coef_value(req_coef_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_value(rsp_out_value),
      .rsp_clamped(rsp_clamped), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit stall_now();
      return !calm && ($urandom_range(0, 99) < 12);
   endfunction

   // output side: random back-pressure, check at the rising edge
   always @(negedge clock) begin
      rsp_ready <= !reset && !stall_now();
   end

   always @(posedge clock) begin
      out_pixel_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.x = rsp_out_x;
         got.y = rsp_out_y;
         got.value = rsp_out_value;
         got.clamped = rsp_clamped;
         got.last = rsp_last;
         book.check_pixel(got);
      end
   end

   // one item; valid stays high into the next call unless a gap is taken
   task automatic send(bit cmd, bit [kcb_pkg::PIX_W-1:0] pv,
                       bit [kcb_pkg::CIDX_W-1:0] ci, bit [7:0] cv);
      @(negedge clock);
      while (stall_now()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_cmd = cmd;
      req_pixel_value = pv;
      req_coef_index = ci;
      req_coef_value = cv;
      do @(posedge clock); while (!req_ready);
      book.take_item(cmd, pv, ci, cv);
      fed++;
   endtask

   task automatic send_pixel(bit [kcb_pkg::PIX_W-1:0] pv);
      send(kcb_pkg::CMD_PIXEL, pv, kcb_pkg::CIDX_W'($urandom_range(0, 127)),
           8'($urandom_range(0, 255)));
   endtask

   task automatic send_coef(bit [kcb_pkg::CIDX_W-1:0] ci, bit [7:0] cv);
      send(kcb_pkg::CMD_COEF, kcb_pkg::PIX_W'($urandom_range(0, 255)), ci, cv);
   endtask

   function automatic bit [kcb_pkg::PIX_W-1:0] rand_pixel();
      int k;
      k = $urandom_range(0, 9);
      return (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(0, 255));
   endfunction

   // wait for every due pixel, then for queued coefficient items to clear
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (book.due_pixels.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_reg(bit [kcb_pkg::CSR_IDX_W-1:0] idx,
                          bit [kcb_pkg::CSR_DAT_W-1:0] d);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = d;
      @(negedge clock);
      csr_we = 1'b0;
      book.write_reg(idx, d);
   endtask

   task automatic set_frame(int w, int h, int r, int b);
      set_reg(kcb_pkg::CSR_FRAME_WIDTH, kcb_pkg::CSR_DAT_W'(w));
      set_reg(kcb_pkg::CSR_FRAME_HEIGHT, kcb_pkg::CSR_DAT_W'(h));
      set_reg(kcb_pkg::CSR_KERNEL_RADIUS, kcb_pkg::CSR_DAT_W'(r));
      set_reg(kcb_pkg::CSR_OUTPUT_BIAS, kcb_pkg::CSR_DAT_W'(b));
   endtask

   task automatic random_weights(int n);
      for (int i = 0; i < n; i++)
         if ($urandom_range(0, 7) == 0)
            send_coef(kcb_pkg::CIDX_W'($urandom_range(KSQ, 127)),
                      8'($urandom_range(0, 255)));
         else
            send_coef(kcb_pkg::CIDX_W'($urandom_range(0, KSQ - 1)),
                      8'($urandom_range(0, 255)));
   endtask

   initial begin
      int w, h, b, frames;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: weight extremes, ignored indexes, saturated radius, high clamp
      set_frame(3, 2, 7, 32767);
      send_coef(7'd40, 8'sd127);
      send_coef(7'd0, 8'h80);
      send_coef(kcb_pkg::CIDX_W'(KSQ - 1), 8'd1);
      send_coef(kcb_pkg::CIDX_W'(KSQ), 8'd5);
      send_coef(7'd127, 8'hff);
      send_pixel(8'd255);
      send_pixel(8'd0);
      send_pixel(8'd128);
      send_pixel(8'd255);
      send_pixel(8'd1);
      send_pixel(8'd254);
      drain();
      // zero width and height act as one, radius zero, low clamp
      set_frame(0, 0, 0, 16'h8000);
      send_pixel(8'd200);
      send_pixel(8'd17);
      drain();

      // random frames; the first stretch runs without any stalls
      frames = 0;
      while (fed < 200) begin
         calm = (frames < 8);
         w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
         h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                         : 16'($urandom_range(0, 400) - 200);
         set_frame(w, h, $urandom_range(0, 7), b);
         if ($urandom_range(0, 1)) random_weights($urandom_range(3, 12));
         if (w == 0) w = 1;
         if (h == 0) h = 1;
         for (int i = 0; i < w * h; i++) begin
            if ($urandom_range(0, 9) == 0) random_weights(1);
            send_pixel(rand_pixel());
         end
         drain();
         frames++;
      end
      calm = 1'b0;

      // frame narrowed partway: the column count lands beyond the new width
      set_frame(8, 6, 2, 127);
      for (int i = 0; i < 2 * 8 + 5; i++) send_pixel(rand_pixel());
      drain();
      set_reg(kcb_pkg::CSR_FRAME_WIDTH, 16'd4);
      for (int i = 0; i < 4 * 4; i++) send_pixel(rand_pixel());
      drain();

      // very tall frame cut short: the row count lands beyond the new height
      set_frame(3, 8191, 1, 0);
      for (int i = 0; i < 4 * 3; i++) send_pixel(rand_pixel());
      drain();
      set_reg(kcb_pkg::CSR_FRAME_HEIGHT, 16'd2);
      for (int i = 0; i < 3; i++) send_pixel(rand_pixel());
      drain();

      // over-range width acts as the maximum: a row start of the widest frame
      set_frame(2047, 1, 0, 0);
      for (int i = 0; i < 40; i++) send_pixel(rand_pixel());
      drain();
      repeat (100) @(posedge clock);

      if (book.fails == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

### kernel_convolution_bias_clamp.f
sv/kcb_pkg.sv
sv/kcb_front.sv
sv/kcb_queue.sv
sv/kcb_back.sv
sv/kernel_convolution_bias_clamp.sv
verif/kernel_convolution_bias_clamp_tb.sv
